// ===== hw/rtl/dq_pkg.sv =====
package dq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
   localparam logic [1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [1:0] OP_POP_BACK   = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

   localparam logic signed [31:0] NONE_WORD = -32'sd1;

   // One-hot per transaction; all low when the operation is refused.
   typedef struct packed {
      logic shift_right;   // push front
      logic shift_left;    // pop front
      logic append;        // push back
      logic trim;          // pop back
   } ctrl_type;

endpackage

// ===== hw/rtl/double_ended_queue.sv =====
// Channel  | Direction | Ports                                               | Moves
// req      | in        | req_valid, req_ready, req_opcode, req_value         | one operation
// rsp      | out       | rsp_valid, rsp_ready, rsp_popped, rsp_status,       | one result
//          |           | rsp_head_word, rsp_tail_word, rsp_is_empty          |
// Words sit in a row of DEPTH cells, front word always in cell 0; pushes and
// pops at the front shift the whole row one cell at once.
// One transaction per cycle while req_ready is high; its result is registered and shows the cycle after.
// req_ready is low only while a result waits and rsp_ready is low.
// Synchronous reset empties the row (cell valid bits cleared).
module double_ended_queue #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_popped,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_head_word,
   output logic signed [31:0] rsp_tail_word,
   output logic               rsp_is_empty
);

   logic signed [31:0] cell_data [DEPTH+1];
   logic               cell_valid [DEPTH+2];
   logic signed [31:0] tail_taps [DEPTH];
   logic signed [31:0] pen_taps [DEPTH];

   dq_pkg::ctrl_type   ctrl;
   logic               fire, empty, full;
   logic signed [31:0] cur_head, cur_tail, pen_tail;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] popped_ff, popped_in;
   logic [1:0]         status_ff, status_in;
   logic signed [31:0] head_ff, head_in;
   logic signed [31:0] tail_ff, tail_in;
   logic               is_empty_ff, is_empty_in;

   assign cell_data[DEPTH]    = '0;
   assign cell_valid[DEPTH]   = 1'b0;
   assign cell_valid[DEPTH+1] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      dq_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .push_value   (req_value),
         .left_data    ((i == 0) ? req_value : cell_data[(i == 0) ? 0 : i-1]),
         .left_valid   ((i == 0) ? 1'b1 : cell_valid[(i == 0) ? 0 : i-1]),
         .right_data   (cell_data[i+1]),
         .right_valid  (cell_valid[i+1]),
         .right2_valid (cell_valid[i+2]),
         .data_out     (cell_data[i]),
         .valid_out    (cell_valid[i]),
         .tail_tap     (tail_taps[i]),
         .pen_tap      (pen_taps[i])
      );
   end

   always_comb begin
      cur_tail = '0;
      pen_tail = '0;
      for (int i = 0; i < DEPTH; i++) begin
         cur_tail = cur_tail | tail_taps[i];
         pen_tail = pen_tail | pen_taps[i];
      end
   end

   assign empty    = !cell_valid[0];
   assign full     = cell_valid[DEPTH-1];
   assign cur_head = cell_data[0];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   always_comb begin
      ctrl = '0;
      if (fire) begin
         unique case (req_opcode)
            dq_pkg::OP_PUSH_FRONT: ctrl.shift_right = !full;
            dq_pkg::OP_PUSH_BACK:  ctrl.append      = !full;
            dq_pkg::OP_POP_FRONT:  ctrl.shift_left  = !empty;
            dq_pkg::OP_POP_BACK:   ctrl.trim        = !empty;
            default:               ctrl = '0;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      popped_in    = popped_ff;
      status_in    = status_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      is_empty_in  = is_empty_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         popped_in    = dq_pkg::NONE_WORD;
         status_in    = dq_pkg::STATUS_OK;
         head_in      = empty ? dq_pkg::NONE_WORD : cur_head;
         tail_in      = empty ? dq_pkg::NONE_WORD : cur_tail;
         is_empty_in  = empty;
         unique case (req_opcode)
            dq_pkg::OP_PUSH_FRONT: begin
               if (full) begin
                  status_in = dq_pkg::STATUS_PUSH_FULL;
               end else begin
                  head_in     = req_value;
                  tail_in     = empty ? req_value : cur_tail;
                  is_empty_in = 1'b0;
               end
            end
            dq_pkg::OP_PUSH_BACK: begin
               if (full) begin
                  status_in = dq_pkg::STATUS_PUSH_FULL;
               end else begin
                  head_in     = empty ? req_value : cur_head;
                  tail_in     = req_value;
                  is_empty_in = 1'b0;
               end
            end
            dq_pkg::OP_POP_FRONT: begin
               if (empty) begin
                  status_in = dq_pkg::STATUS_POP_EMPTY;
               end else begin
                  popped_in   = cur_head;
                  head_in     = cell_valid[1] ? cell_data[1] : dq_pkg::NONE_WORD;
                  tail_in     = cell_valid[1] ? cur_tail : dq_pkg::NONE_WORD;
                  is_empty_in = !cell_valid[1];
               end
            end
            dq_pkg::OP_POP_BACK: begin
               if (empty) begin
                  status_in = dq_pkg::STATUS_POP_EMPTY;
               end else begin
                  popped_in   = cur_tail;
                  head_in     = cell_valid[1] ? cur_head : dq_pkg::NONE_WORD;
                  tail_in     = cell_valid[1] ? pen_tail : dq_pkg::NONE_WORD;
                  is_empty_in = !cell_valid[1];
               end
            end
            default: status_in = dq_pkg::STATUS_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      popped_ff   <= popped_in;
      status_ff   <= status_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      is_empty_ff <= is_empty_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_popped    = popped_ff;
   assign rsp_status    = status_ff;
   assign rsp_head_word = head_ff;
   assign rsp_tail_word = tail_ff;
   assign rsp_is_empty  = is_empty_ff;

endmodule

// ===== hw/rtl/dq_cell.sv =====
module dq_cell (
   input  logic                clock,
   input  logic                reset,
   input  dq_pkg::ctrl_type    ctrl,
   input  logic signed [31:0]  push_value,
   input  logic signed [31:0]  left_data,
   input  logic                left_valid,
   input  logic signed [31:0]  right_data,
   input  logic                right_valid,
   input  logic                right2_valid,
   output logic signed [31:0]  data_out,
   output logic                valid_out,
   output logic signed [31:0]  tail_tap,
   output logic signed [31:0]  pen_tap
);

   logic signed [31:0] data_ff, data_in;
   logic               valid_ff, valid_in;
   logic               is_last, is_pen;

   assign is_last = valid_ff && !right_valid;
   assign is_pen  = valid_ff && right_valid && !right2_valid;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.shift_right) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (ctrl.shift_left) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (ctrl.append && !valid_ff && left_valid) begin
         data_in  = push_value;
         valid_in = 1'b1;
      end else if (ctrl.trim && is_last) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign data_out  = data_ff;
   assign valid_out = valid_ff;
   assign tail_tap  = is_last ? data_ff : '0;
   assign pen_tap   = is_pen ? data_ff : '0;

endmodule

// ===== tb/double_ended_queue_test.sv =====
module double_ended_queue_test;

   localparam int          RING_SIZE   = dq_pkg::DEPTH_DEFAULT;
   localparam int unsigned RANDOM_OPS  = 1800;
   localparam int unsigned CYCLE_LIMIT = 250000;
   localparam int unsigned MAX_GAP     = 11;

   typedef struct packed {
      logic signed [31:0] popped;
      logic [1:0]         status;
      logic signed [31:0] head_word;
      logic signed [31:0] tail_word;
      logic               is_empty;
   } deque_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_opcode = dq_pkg::OP_PUSH_FRONT;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_popped;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_head_word;
   logic signed [31:0] rsp_tail_word;
   logic               rsp_is_empty;

   // Shadow deque kept as a ring, front word at ring_head
   logic signed [31:0] ring_words [RING_SIZE];
   int unsigned        ring_head = 0;
   int unsigned        ring_fill = 0;

   deque_result_type expected_results [$];
   int unsigned      mismatches = 0;
   bit               pace_on = 1'b1;

   double_ended_queue i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_popped    (rsp_popped),
      .rsp_status    (rsp_status),
      .rsp_head_word (rsp_head_word),
      .rsp_tail_word (rsp_tail_word),
      .rsp_is_empty  (rsp_is_empty)
   );

   always #4 clock = ~clock;

   function automatic deque_result_type apply_op(logic [1:0] op, logic signed [31:0] word);
      deque_result_type r;
      r.popped = dq_pkg::NONE_WORD;
      r.status = dq_pkg::STATUS_OK;
      case (op) inside
         dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
            if (ring_fill == RING_SIZE) begin
               r.status = dq_pkg::STATUS_PUSH_FULL;
            end else if (op == dq_pkg::OP_PUSH_FRONT) begin
               ring_head = (ring_head + RING_SIZE - 1) % RING_SIZE;
               ring_words[ring_head] = word;
               ring_fill++;
            end else begin
               ring_words[(ring_head + ring_fill) % RING_SIZE] = word;
               ring_fill++;
            end
         end
         default: begin
            if (ring_fill == 0) begin
               r.status = dq_pkg::STATUS_POP_EMPTY;
            end else if (op == dq_pkg::OP_POP_FRONT) begin
               r.popped = ring_words[ring_head];
               ring_head = (ring_head + 1) % RING_SIZE;
               ring_fill--;
            end else begin
               r.popped = ring_words[(ring_head + ring_fill - 1) % RING_SIZE];
               ring_fill--;
            end
         end
      endcase
      if (ring_fill == 0) begin
         r.head_word = dq_pkg::NONE_WORD;
         r.tail_word = dq_pkg::NONE_WORD;
         r.is_empty  = 1'b1;
      end else begin
         r.head_word = ring_words[ring_head];
         r.tail_word = ring_words[(ring_head + ring_fill - 1) % RING_SIZE];
         r.is_empty  = 1'b0;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return dq_pkg::NONE_WORD;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Called at a rising edge; returns at the edge where the transaction is taken.
   task automatic send_op(input logic [1:0] op, input logic signed [31:0] word);
      int unsigned gap;
      gap = pace_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= word;
      expected_results.push_back(apply_op(op, word));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic test_empty_and_extremes();
      pace_on = 1'b1;
      send_op(dq_pkg::OP_POP_FRONT, 32'h1234_5678);
      send_op(dq_pkg::OP_POP_BACK, 32'h8765_4321);
      send_op(dq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff);
      send_op(dq_pkg::OP_PUSH_BACK, 32'h8000_0000);
      send_op(dq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
      send_op(dq_pkg::OP_PUSH_BACK, dq_pkg::NONE_WORD);
      send_op(dq_pkg::OP_POP_FRONT, '0);
      send_op(dq_pkg::OP_POP_BACK, '0);
      send_op(dq_pkg::OP_POP_BACK, '0);
      // last word out
      send_op(dq_pkg::OP_POP_FRONT, '0);
      send_op(dq_pkg::OP_POP_FRONT, '0);
   endtask

   task automatic test_fill_to_capacity();
      pace_on = 1'b0;
      for (int i = 0; i < RING_SIZE; i++)
         send_op(i[0] ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT, $urandom);
      send_op(dq_pkg::OP_PUSH_FRONT, 32'h5555_aaaa);
      send_op(dq_pkg::OP_PUSH_BACK, 32'haaaa_5555);
   endtask

   task automatic test_random_traffic();
      int unsigned sent_ops;
      int unsigned phase_len;
      int unsigned push_pct;
      logic [1:0]  op;
      sent_ops = 0;
      while (sent_ops < RANDOM_OPS) begin
         phase_len = $urandom_range(20, 120);
         case ($urandom_range(0, 2))
            0:       push_pct = 80;
            1:       push_pct = 20;
            default: push_pct = 50;
         endcase
         pace_on = ($urandom_range(0, 3) != 0);
         repeat (phase_len) begin
            if ($urandom_range(1, 100) <= push_pct)
               op = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
            else
               op = $urandom_range(0, 1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
            send_op(op, pick_word());
            sent_ops++;
         end
         if ($urandom_range(0, 4) == 0) drain_results();
      end
   endtask

   always begin : result_pacing
      int unsigned stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pace_on ? $urandom_range(0, MAX_GAP) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      deque_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result transaction with no expectation pending");
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            check_field("popped", want.popped, rsp_popped);
            check_field("status", want.status, rsp_status);
            check_field("head_word", want.head_word, rsp_head_word);
            check_field("tail_word", want.tail_word, rsp_tail_word);
            check_field("is_empty", want.is_empty, rsp_is_empty);
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[double_ended_queue] ERROR");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_extremes();
      test_fill_to_capacity();
      // hold off until the full deque has reported back
      drain_results();
      test_random_traffic();
      drain_results();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("[double_ended_queue] OK");
      else
         $display("[double_ended_queue] ERROR");
      $finish;
   end

endmodule
